// File: sv/lhsa_pkg.sv
// Shared types and constants for the height grid scatter address block.
// No dependencies; every other file refers to it by scoped names.
package lhsa_pkg;

    // Position arithmetic width: coordinates reach 2^15, sums of two strides reach 2^17
    localparam int unsigned WALK_W = 18;
    localparam int unsigned POS_W  = 16;
    localparam int unsigned ADDR_W = 31;

    localparam logic [3:0] GRID_LOG2_RESET = 4'd9;
    localparam logic [4:0] LOD_COUNT_RESET = 5'd5;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_GRID_LOG2 = 1'b0,
        CFG_LOD_COUNT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic        start_level;
        logic [3:0]  lod_level;
        logic [31:0] height_bits;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] grid_address;
        logic [31:0]       height_out;
        logic              last_of_level;
        logic              bad_sample;
    } out_item_t;

    // Walk state kept between items
    typedef struct packed {
        logic [POS_W-1:0] column_pos;
        logic [POS_W-1:0] row_pos;
        logic [3:0]       current_level;
        logic             level_complete;
    } walk_state_t;

endpackage

// File: sv/lhsa_walk.sv
// One step of the level walk: checks the item, forms its address and the next position.
// Purely combinational; uses types and widths from lhsa_pkg.
module lhsa_walk (
    input  lhsa_pkg::in_item_t    item,
    input  logic [3:0]            grid_log2,
    input  logic [4:0]            lod_count,
    input  lhsa_pkg::walk_state_t walk,
    output lhsa_pkg::out_item_t   result,
    output lhsa_pkg::walk_state_t walk_next
);

    logic [lhsa_pkg::WALK_W-1:0] side_m1;
    logic [lhsa_pkg::WALK_W-1:0] side;
    logic [lhsa_pkg::WALK_W-1:0] inc;
    logic [lhsa_pkg::WALK_W-1:0] pm;
    logic                        top;
    logic                        in_range;

    logic [lhsa_pkg::WALK_W-1:0] start_x;
    logic [lhsa_pkg::WALK_W-1:0] start_y;
    logic                        start_found;
    logic [lhsa_pkg::WALK_W-1:0] cur_x;
    logic [lhsa_pkg::WALK_W-1:0] cur_y;
    logic                        proceed;

    logic                        even_row;
    logic [lhsa_pkg::WALK_W-1:0] x_two;
    logic [lhsa_pkg::WALK_W-1:0] x_one;
    logic [lhsa_pkg::WALK_W-1:0] ny;
    logic [lhsa_pkg::WALK_W-1:0] ent_x;
    logic [lhsa_pkg::WALK_W-1:0] ent_y;
    logic                        ent_found;
    logic [lhsa_pkg::WALK_W-1:0] nx_pos;
    logic [lhsa_pkg::WALK_W-1:0] ny_pos;
    logic                        more;

    logic [lhsa_pkg::POS_W-1:0]  flip_row;
    logic [lhsa_pkg::ADDR_W-1:0] address;

    // First filled position of an even row ny (both coordinates on the coarser level)
    function automatic logic [2*lhsa_pkg::WALK_W:0] even_entry(
        input logic [lhsa_pkg::WALK_W-1:0] row,
        input logic [lhsa_pkg::WALK_W-1:0] stride,
        input logic [lhsa_pkg::WALK_W-1:0] s_m1
    );
        logic [lhsa_pkg::WALK_W-1:0] row2;
        row2 = row + stride;
        if (stride < s_m1) begin
            even_entry = {1'b1, stride, row};
        end else if (row2 < s_m1 + lhsa_pkg::WALK_W'(1)) begin
            even_entry = {1'b1, lhsa_pkg::WALK_W'(0), row2};
        end else begin
            even_entry = {1'b0, lhsa_pkg::WALK_W'(0), lhsa_pkg::WALK_W'(0)};
        end
    endfunction

    // Grid geometry and level flags
    always_comb
    begin
        side_m1  = lhsa_pkg::WALK_W'(1) << grid_log2;
        side     = side_m1 + lhsa_pkg::WALK_W'(1);
        inc      = lhsa_pkg::WALK_W'(1) << item.lod_level;
        pm       = (lhsa_pkg::WALK_W'(2) << item.lod_level) - lhsa_pkg::WALK_W'(1);
        top      = ({1'b0, item.lod_level} + 5'd1) == lod_count;
        in_range = {1'b0, item.lod_level} < lod_count;
    end

    // Starting position of a new level
    always_comb
    begin
        if (top) begin
            start_found = 1'b1;
            start_x     = '0;
            start_y     = '0;
        end else begin
            {start_found, start_x, start_y} = even_entry('0, inc, side_m1);
        end
    end

    // Select the position this item fills and decide whether it is taken
    always_comb
    begin
        if (item.start_level) begin
            cur_x   = start_x;
            cur_y   = start_y;
            proceed = in_range && start_found;
        end else begin
            cur_x   = lhsa_pkg::WALK_W'(walk.column_pos);
            cur_y   = lhsa_pkg::WALK_W'(walk.row_pos);
            proceed = in_range && !walk.level_complete
                      && (item.lod_level == walk.current_level);
        end
    end

    // Advance to the next filled position of the level
    always_comb
    begin
        even_row = !top && ((cur_y & pm) == '0);
        x_two    = cur_x + (inc << 1);
        x_one    = cur_x + inc;
        ny       = cur_y + inc;
        {ent_found, ent_x, ent_y} = even_entry(ny, inc, side_m1);
        nx_pos   = '0;
        ny_pos   = '0;
        more     = 1'b0;
        if (even_row && (x_two < side_m1)) begin
            nx_pos = x_two;
            ny_pos = cur_y;
            more   = 1'b1;
        end else if (!even_row && (cur_x != side_m1)) begin
            nx_pos = (x_one >= side_m1) ? side_m1 : x_one;
            ny_pos = cur_y;
            more   = 1'b1;
        end else if (ny >= side) begin
            more   = 1'b0;
        end else if (top || ((ny & pm) != '0)) begin
            nx_pos = '0;
            ny_pos = ny;
            more   = 1'b1;
        end else begin
            nx_pos = ent_x;
            ny_pos = ent_y;
            more   = ent_found;
        end
    end

    // Row-mirrored address: (2^g - y) * (2^g + 1) + x as shift and add
    always_comb
    begin
        flip_row = lhsa_pkg::POS_W'(side_m1 - cur_y);
        address  = (lhsa_pkg::ADDR_W'(flip_row) << grid_log2)
                   + lhsa_pkg::ADDR_W'(flip_row) + lhsa_pkg::ADDR_W'(cur_x);
    end

    // Form the result item and the next walk state
    always_comb
    begin
        walk_next            = walk;
        result.height_out    = item.height_bits;
        result.grid_address  = proceed ? address : '0;
        result.last_of_level = proceed && !more;
        result.bad_sample    = !proceed;
        if (in_range && item.start_level) begin
            walk_next.current_level = item.lod_level;
            if (!start_found) begin
                walk_next.level_complete = 1'b1;
            end
        end
        if (proceed) begin
            if (more) begin
                walk_next.column_pos     = lhsa_pkg::POS_W'(nx_pos);
                walk_next.row_pos        = lhsa_pkg::POS_W'(ny_pos);
                walk_next.level_complete = 1'b0;
            end else begin
                walk_next.column_pos     = lhsa_pkg::POS_W'(cur_x);
                walk_next.row_pos        = lhsa_pkg::POS_W'(cur_y);
                walk_next.level_complete = 1'b1;
            end
        end
    end

endmodule

// File: sv/lod_heightmap_scatter_address.sv
// Top level of the height grid scatter address block: channel registers and config.
// Depends on lhsa_pkg and lhsa_walk.
//
// Usage:
//   sample channel (sample_valid / sample_stall / sample) carries one height item
//   with its level and start mark. result channel (result_valid / result_stall /
//   result) returns exactly one item per sample: mirrored grid address, the height
//   bits, a last-of-level mark and a reject flag.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes grid_log2
//   (index 0) or lod_count (index 1); cfg_ready is always high and any write ends
//   the active level. Write only while no item is in flight.
// Timing:
//   A sample lands in the input register, the walk step runs between that register
//   and the result register, so a result is presented from the result register
//   once the item moves on. One item per cycle is sustained while result_stall
//   stays low; the walk state update is one pass of compare-and-add logic, and
//   the address is a single shift-add.
// Reset: registers return to grid_log2 = 9, lod_count = 5, no level active.
// Stall: with result_stall high a full result register holds; the input register
//   still fills, and sample_stall rises only when both registers are occupied.
module lod_heightmap_scatter_address (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  lhsa_pkg::in_item_t  sample,
    output logic                result_valid,
    input  logic                result_stall,
    output lhsa_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [4:0]          cfg_data
);

    logic [3:0]            grid_log2_reg;
    logic [3:0]            grid_log2_next;
    logic [4:0]            lod_count_reg;
    logic [4:0]            lod_count_next;
    lhsa_pkg::walk_state_t walk_reg;
    lhsa_pkg::walk_state_t walk_next;
    lhsa_pkg::walk_state_t step_walk;
    logic                  hold_valid_reg;
    logic                  hold_valid_next;
    lhsa_pkg::in_item_t    hold_item_reg;
    lhsa_pkg::out_item_t   step_result;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    lhsa_pkg::out_item_t   out_item_reg;
    logic                  out_free;
    logic                  hold_move;
    logic                  cfg_write;

    // Walk step between the input register and the result register
    lhsa_walk u_walk (
        .item      (hold_item_reg),
        .grid_log2 (grid_log2_reg),
        .lod_count (lod_count_reg),
        .walk      (walk_reg),
        .result    (step_result),
        .walk_next (step_walk)
    );

    // Handshake: move the held item forward whenever the result register frees up
    always_comb
    begin
        out_free        = !out_valid_reg || !result_stall;
        hold_move       = hold_valid_reg && out_free;
        sample_stall    = hold_valid_reg && !out_free;
        hold_valid_next = (hold_valid_reg && !hold_move) || sample_valid;
        out_valid_next  = hold_move || (out_valid_reg && result_stall);
        cfg_ready       = 1'b1;
        cfg_write       = cfg_valid;
    end

    // Config writes and walk state update; a write ends the active level
    always_comb
    begin
        grid_log2_next = grid_log2_reg;
        lod_count_next = lod_count_reg;
        walk_next      = hold_move ? step_walk : walk_reg;
        if (cfg_write) begin
            case (lhsa_pkg::cfg_index_t'(cfg_index))
                lhsa_pkg::CFG_GRID_LOG2: grid_log2_next = cfg_data[3:0];
                lhsa_pkg::CFG_LOD_COUNT: lod_count_next = cfg_data;
                default:                 grid_log2_next = grid_log2_reg;
            endcase
            walk_next.level_complete = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            grid_log2_reg  <= lhsa_pkg::GRID_LOG2_RESET;
            lod_count_reg  <= lhsa_pkg::LOD_COUNT_RESET;
            walk_reg       <= '{column_pos: '0, row_pos: '0, current_level: '0,
                                level_complete: 1'b1};
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            grid_log2_reg  <= grid_log2_next;
            lod_count_reg  <= lod_count_next;
            walk_reg       <= walk_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: load the input item when accepted, the result when it moves
    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall) begin
            hold_item_reg <= sample;
        end
        if (hold_move) begin
            out_item_reg <= step_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

// File: test/tb_top.sv
// Self-checking bench for lod_heightmap_scatter_address: random level walks, idling on
// both channels and config sweeps, checked item by item against an in-bench walk model.
// Depends on lhsa_pkg and the lod_heightmap_scatter_address RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 40;
    localparam int HOLD_AFTER  = 300;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    lhsa_pkg::in_item_t   sample = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    lhsa_pkg::out_item_t  result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    lhsa_pkg::cfg_index_t cfg_idx = lhsa_pkg::CFG_GRID_LOG2;
    logic [4:0]           cfg_data = '0;

    // Walk model state and its copy of the registers
    logic [3:0]  reg_grid_log2;
    logic [4:0]  reg_lod_count;
    int unsigned wk_col;
    int unsigned wk_row;
    int unsigned wk_level;
    bit          wk_done;

    lhsa_pkg::in_item_t  height_feed_q[$];
    lhsa_pkg::out_item_t scatter_expect_q[$];
    lhsa_pkg::out_item_t want_item;

    int          feed_total = 0;
    int          fed_count = 0;
    int          mismatch_count = 0;
    int          levels_finished = 0;
    int          rejects_seen = 0;
    int          settings_run = 1;
    int          quiet_cycles = 0;
    int          idle_pct = 0;
    bit          calm = 1'b0;
    bit          in_fire = 1'b0;
    int          in_gap = 0;
    int          out_gap = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    lod_heightmap_scatter_address dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_idx),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // True when (x,y) is stored on this level (coarser positions are skipped)
    function automatic bit pos_filled(input int unsigned lvl, input bit top,
                                      input int unsigned x, input int unsigned y);
        int unsigned side;
        int unsigned pm;
        side = (1 << reg_grid_log2) + 1;
        pm = (2 << lvl) - 1;
        if (top)
            return 1'b1;
        if (x != side - 1 && (x & pm) != 0)
            return 1'b1;
        return (y & pm) != 0;
    endfunction

    // Advance one grid step; the last column closes each row
    function automatic bit pos_step(input int unsigned lvl,
                                    inout int unsigned x, inout int unsigned y);
        int unsigned side;
        int unsigned inc;
        side = (1 << reg_grid_log2) + 1;
        inc = 1 << lvl;
        if (x == side - 1)
        begin
            if (y + inc >= side)
                return 1'b0;
            y = y + inc;
            x = 0;
        end
        else
        begin
            x = (x + inc >= side - 1) ? side - 1 : x + inc;
        end
        return 1'b1;
    endfunction

    // Skip forward to the next stored position, inclusive
    function automatic bit pos_seek(input int unsigned lvl, input bit top,
                                    inout int unsigned x, inout int unsigned y);
        while (!pos_filled(lvl, top, x, y))
        begin
            if (!pos_step(lvl, x, y))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Compute the scattered address for one sample and advance the walk
    function automatic lhsa_pkg::out_item_t scatter_predict(input lhsa_pkg::in_item_t it);
        lhsa_pkg::out_item_t r;
        int unsigned side;
        int unsigned lvl;
        int unsigned x;
        int unsigned y;
        int unsigned nx;
        int unsigned ny;
        bit          top;
        bit          more;
        side = (1 << reg_grid_log2) + 1;
        lvl = it.lod_level;
        top = (lvl + 1 == reg_lod_count);
        r.grid_address = '0;
        r.height_out = it.height_bits;
        r.last_of_level = 1'b0;
        r.bad_sample = 1'b1;
        if (lvl >= reg_lod_count)
            return r;
        if (it.start_level)
        begin
            x = 0;
            y = 0;
            wk_level = lvl;
            if (!pos_seek(lvl, top, x, y))
            begin
                wk_done = 1'b1;
                return r;
            end
        end
        else
        begin
            if (wk_done || lvl != wk_level)
                return r;
            x = wk_col;
            y = wk_row;
        end
        if (x >= side || y >= side)
        begin
            wk_done = 1'b1;
            return r;
        end
        r.grid_address = lhsa_pkg::ADDR_W'(longint'(side - 1 - y) * side + x);
        r.bad_sample = 1'b0;
        nx = x;
        ny = y;
        more = pos_step(lvl, nx, ny);
        if (more)
            more = pos_seek(lvl, top, nx, ny);
        if (more)
        begin
            wk_col = nx & 16'hFFFF;
            wk_row = ny & 16'hFFFF;
            wk_done = 1'b0;
        end
        else
        begin
            wk_col = x & 16'hFFFF;
            wk_row = y & 16'hFFFF;
            wk_done = 1'b1;
            r.last_of_level = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_height();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Queue one sample together with its predicted result
    task automatic feed_item(input logic start, input logic [3:0] lvl, input logic [31:0] h);
        lhsa_pkg::in_item_t it;
        it.start_level = start;
        it.lod_level = lvl;
        it.height_bits = h;
        scatter_expect_q.push_back(scatter_predict(it));
        height_feed_q.push_back(it);
        feed_total++;
    endtask

    // Hold until every queued item is through, then let the pipe settle
    task automatic wait_drained();
        while (height_feed_q.size() != 0 || scatter_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input lhsa_pkg::cfg_index_t idx, input logic [4:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        if (idx == lhsa_pkg::CFG_GRID_LOG2)
            reg_grid_log2 = val[3:0];
        else
            reg_lod_count = val;
        wk_done = 1'b1;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(input logic [4:0] g, input logic [4:0] n);
        if ($urandom_range(0, 1))
        begin
            write_reg(lhsa_pkg::CFG_GRID_LOG2, g);
            write_reg(lhsa_pkg::CFG_LOD_COUNT, n);
        end
        else
        begin
            write_reg(lhsa_pkg::CFG_LOD_COUNT, n);
            write_reg(lhsa_pkg::CFG_GRID_LOG2, g);
        end
    endtask

    // Mostly well-formed level walks, some truncated, with noise mixed in
    task automatic feed_phase(input int budget);
        int          base;
        int unsigned lvl;
        int unsigned span;
        int unsigned max_len;
        int unsigned n;
        base = feed_total;
        while (feed_total - base < budget)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                span = (reg_lod_count > 3) ? 2 : reg_lod_count - 1;
                if ($urandom_range(0, 1))
                    lvl = reg_lod_count - 1 - $urandom_range(0, span);
                else
                    lvl = $urandom_range(0, reg_lod_count - 1);
                max_len = ($urandom_range(0, 2) != 0) ? 150 : $urandom_range(1, 10);
                feed_item(1'b1, 4'(lvl), rand_height());
                n = 1;
                while (!wk_done && n < max_len && feed_total - base < budget)
                begin
                    if ($urandom_range(0, 99) < 4)
                        feed_item(1'b0, 4'(lvl ^ (1 << $urandom_range(0, 3))), rand_height());
                    else
                    begin
                        feed_item(1'b0, 4'(lvl), rand_height());
                        n++;
                    end
                end
                if (wk_done && $urandom_range(0, 99) < 30)
                    feed_item(1'b0, 4'(lvl), rand_height());
            end
            else
            begin
                feed_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), rand_height());
            end
        end
    endtask

    // Sample both channels, check results, watch for a hang
    always @(posedge clk)
    begin
        in_fire <= sample_valid && !sample_stall;
        if (sample_valid && !sample_stall)
            fed_count++;
        if (result_valid && !result_stall)
        begin
            if (result.last_of_level === 1'b1)
                levels_finished++;
            if (result.bad_sample === 1'b1)
                rejects_seen++;
            if (scatter_expect_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with no sample pending: addr=%0d height=%h",
                             $realtime, result.grid_address, result.height_out);
            end
            else
            begin
                want_item = scatter_expect_q.pop_front();
                if (result.grid_address !== want_item.grid_address
                    || result.height_out !== want_item.height_out
                    || result.last_of_level !== want_item.last_of_level
                    || result.bad_sample !== want_item.bad_sample)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: want a=%0d h=%h l=%b b=%b, got a=%0d h=%h l=%b b=%b",
                                 $realtime, want_item.grid_address, want_item.height_out,
                                 want_item.last_of_level, want_item.bad_sample,
                                 result.grid_address, result.height_out,
                                 result.last_of_level, result.bad_sample);
                end
            end
        end
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, scatter_expect_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Drive samples: hold an item until taken, insert idle bursts between items
    always @(negedge clk)
    begin
        if (rst_n && !(sample_valid && !in_fire))
        begin
            if (in_fire)
                void'(height_feed_q.pop_front());
            if (in_gap > 0)
            begin
                sample_valid <= 1'b0;
                in_gap--;
            end
            else if (height_feed_q.size() == 0)
                sample_valid <= 1'b0;
            else if (!calm && $urandom_range(0, 99) < idle_pct)
            begin
                sample_valid <= 1'b0;
                in_gap = $urandom_range(0, 2);
            end
            else
            begin
                sample_valid <= 1'b1;
                sample <= height_feed_q[0];
            end
        end
    end

    // Drive result stall: random bursts, plus one long hold to back up the input
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else if (!hold_done && !calm && fed_count >= HOLD_AFTER)
        begin
            result_stall <= 1'b1;
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
        end
        else if (out_gap > 0)
        begin
            result_stall <= 1'b1;
            out_gap--;
        end
        else if (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            result_stall <= 1'b1;
            out_gap = $urandom_range(0, 2);
        end
        else
            result_stall <= 1'b0;
    end

    initial
    begin
        logic [4:0] grid_set [10];
        logic [4:0] lod_set [10];
        grid_set = '{5'd1, 5'd15, 5'd2, 5'd3, 5'd9, 5'd4, 5'd1, 5'd15, 5'd5, 5'd2};
        lod_set  = '{5'd16, 5'd1, 5'd3, 5'd16, 5'd5, 5'd2, 5'd1, 5'd16, 5'd6, 5'd4};
        reg_grid_log2 = lhsa_pkg::GRID_LOG2_RESET;
        reg_lod_count = lhsa_pkg::LOD_COUNT_RESET;
        wk_col = 0;
        wk_row = 0;
        wk_level = 0;
        wk_done = 1'b1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: rejects, a top-level walk, mismatch, restart, level 0 skip
        idle_pct = 30;
        feed_item(1'b0, 4'd0, 32'h0);
        feed_item(1'b1, 4'd15, 32'hFFFF_FFFF);
        feed_item(1'b1, 4'd5, rand_height());
        feed_item(1'b1, 4'd4, 32'hFFFF_FFFF);
        feed_item(1'b0, 4'd4, 32'h0);
        feed_item(1'b0, 4'd3, rand_height());
        feed_item(1'b0, 4'd4, rand_height());
        feed_item(1'b0, 4'd4, rand_height());
        feed_item(1'b1, 4'd3, rand_height());
        repeat (3) feed_item(1'b0, 4'd3, rand_height());
        feed_item(1'b1, 4'd0, rand_height());
        repeat (2) feed_item(1'b0, 4'd0, rand_height());
        wait_drained();

        // Three-wide grid: empty level, short complete levels, samples past the end
        set_grid(5'd1, 5'd5);
        settings_run++;
        feed_item(1'b1, 4'd3, rand_height());
        feed_item(1'b0, 4'd3, rand_height());
        feed_item(1'b1, 4'd4, rand_height());
        feed_item(1'b0, 4'd4, rand_height());
        feed_item(1'b0, 4'd4, rand_height());
        feed_item(1'b1, 4'd1, rand_height());
        feed_item(1'b0, 4'd1, rand_height());
        wait_drained();

        // Random walks over a sweep of grid sizes and level counts
        for (int p = 0; p < 10; p++)
        begin
            if (p == 5)
            begin
                grid_set[p] = 5'($urandom_range(1, 15));
                lod_set[p] = 5'($urandom_range(1, 16));
            end
            idle_pct = (p % 3) * 20;
            calm = (p >= 8);
            set_grid(grid_set[p], lod_set[p]);
            settings_run++;
            feed_phase(112);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        $display("Ran %0d samples over %0d grid settings: %0d levels finished, %0d rejected",
                 fed_count, settings_run, levels_finished, rejects_seen);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
